// ----- rtl/core/sqve_pkg.sv -----
`timescale 1ns / 1ps
// sqve_pkg: item types, constants and fixed-point helpers for the sprite quad
// vertex expander. No dependencies; imported by every module under rtl/core.
package sqve_pkg;

   // angle handling: phase is a 32-bit binary angle, quarter turn = 2^30
   localparam int ANGLE_BITS = 16;
   localparam int ANGLE_SHIFT = 32 - ANGLE_BITS;
   localparam logic [31:0] ANGLE_MASK = 32'((64'd1 << ANGLE_BITS) - 64'd1);
   localparam logic [31:0] QUARTER_TURN = 32'h4000_0000;
   localparam logic [31:0] THREE_QUARTER = 32'hC000_0000;

   // Q2.30 sine polynomial, Horner order from the highest term down
   localparam logic signed [31:0] Q30 = 32'sd1073741824;
   localparam logic signed [31:0] NEG_Q30 = -32'sd1073741824;
   localparam int HORNER_TERMS = 5;
   localparam logic signed [31:0] SINE_COEF [HORNER_TERMS] = '{
      32'sd172272, -32'sd5026995, 32'sd85569306, -32'sd693598668, 32'sd1686629713
   };
   // fold, square, four Horner steps, final product
   localparam int TRIG_STAGES = HORNER_TERMS + 2;
   localparam int LANE_SIN = 0;
   localparam int LANE_COS = 1;

   localparam logic signed [65:0] ROUND_HALF = 66'sd536870912;
   localparam logic signed [39:0] S32_MAX = 40'sd2147483647;
   localparam logic signed [39:0] S32_MIN = -40'sd2147483648;

   localparam int VERTS_PER_SPRITE = 6;
   localparam logic [2:0] LAST_VERTEX = 3'(VERTS_PER_SPRITE - 1);

   typedef enum logic [1:0] {
      CORNER_TL = 2'd0,
      CORNER_BL = 2'd1,
      CORNER_TR = 2'd2,
      CORNER_BR = 2'd3
   } corner_type;

   // two triangles: TL BL TR, TR BL BR
   localparam corner_type CORNER_SEQ [VERTS_PER_SPRITE] = '{
      CORNER_TL, CORNER_BL, CORNER_TR, CORNER_TR, CORNER_BL, CORNER_BR
   };

   typedef struct packed {
      logic [47:0]        position_packed;
      logic signed [31:0] width;
      logic signed [31:0] height;
      logic signed [31:0] pivot_x;
      logic signed [31:0] pivot_y;
      logic [15:0]        angle;
      logic signed [31:0] tex_origin_u;
      logic signed [31:0] tex_origin_v;
      logic signed [31:0] tex_extent_u;
      logic signed [31:0] tex_extent_v;
      logic [31:0]        texture_id;
      logic               final_sprite;
   } req_type;

   typedef struct packed {
      logic [47:0]        vertex_position;
      logic signed [31:0] corner_offset_x;
      logic signed [31:0] corner_offset_y;
      logic signed [31:0] tex_u;
      logic signed [31:0] tex_v;
      logic [31:0]        vertex_texture;
      logic [1:0]         corner;
      logic               last_of_sprite;
      logic               last_of_batch;
   } rsp_type;

   // per-sprite geometry, pivot already subtracted
   typedef struct packed {
      logic [47:0]        position;
      logic signed [32:0] dx_left;
      logic signed [32:0] dx_right;
      logic signed [32:0] dy_top;
      logic signed [32:0] dy_bot;
      logic signed [31:0] u0;
      logic signed [31:0] u1;
      logic signed [31:0] v0;
      logic signed [31:0] v1;
      logic [31:0]        texture;
      logic               final_sprite;
   } geo_type;

   typedef struct packed {
      logic signed [31:0] sin_q30;
      logic signed [31:0] cos_q30;
      geo_type            geo;
   } sprite_type;

   // fold phase into [-2^30, 2^30]; the first and last ranges are the phase
   // read as signed
   function automatic logic signed [31:0] fold_phase(input logic [31:0] t);
      logic signed [32:0] diff;
      diff = 33'sh0_8000_0000 - $signed({1'b0, t});
      if (t < QUARTER_TURN || t >= THREE_QUARTER) begin
         return $signed(t);
      end
      return 32'(diff);
   endfunction

   function automatic logic signed [63:0] mul_floor30(input logic signed [31:0] a,
                                                      input logic signed [31:0] b);
      logic signed [63:0] prod;
      prod = 64'(a) * 64'(b);
      return prod >>> 30;
   endfunction

   function automatic logic signed [31:0] horner_step(input logic signed [31:0] coef,
                                                      input logic signed [31:0] p,
                                                      input logic signed [31:0] z2);
      return 32'(64'(coef) + mul_floor30(p, z2));
   endfunction

   function automatic logic signed [31:0] sine_finish(input logic signed [31:0] p,
                                                      input logic signed [31:0] z);
      logic signed [63:0] s;
      s = mul_floor30(p, z);
      if (s > 64'(Q30)) begin
         return Q30;
      end else if (s < 64'(NEG_Q30)) begin
         return NEG_Q30;
      end
      return 32'(s);
   endfunction

   function automatic logic signed [31:0] sat32(input logic signed [39:0] v);
      if (v > S32_MAX) begin
         return 32'(S32_MAX);
      end else if (v < S32_MIN) begin
         return 32'(S32_MIN);
      end
      return 32'(v);
   endfunction

endpackage

// ----- rtl/core/sqve_trig_pipe.sv -----
`timescale 1ns / 1ps
// sqve_trig_pipe: input register plus a seven-stage pipeline that evaluates
// sine and cosine of the sprite angle and prepares corner deltas. Uses sqve_pkg.
module sqve_trig_pipe (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   output logic                in_ready,
   input  sqve_pkg::req_type   in_data,
   output logic                out_valid,
   input  logic                out_ready,
   output sqve_pkg::sprite_type out_data
);
   import sqve_pkg::*;

   typedef struct packed {
      logic [1:0][31:0] z;
      logic [1:0][31:0] z2;
      logic [1:0][31:0] p;
      geo_type          geo;
   } trig_stage_type;

   req_type                item_ff;
   logic                   item_v_ff;
   logic                   item_free;
   trig_stage_type         st_ff [TRIG_STAGES];
   trig_stage_type         st_in [TRIG_STAGES];
   logic [TRIG_STAGES-1:0] st_v_ff;
   logic [TRIG_STAGES:0]   stage_free;
   logic [31:0]            phase;

   // a stage may load when it is empty or its item moves on this cycle
   always_comb begin
      stage_free[TRIG_STAGES] = out_ready;
      for (int j = TRIG_STAGES - 1; j >= 0; j--) begin
         stage_free[j] = !st_v_ff[j] || stage_free[j+1];
      end
      item_free = !item_v_ff || stage_free[0];
   end

   assign in_ready = item_free;

   // stage 0: phase fold and geometry
   always_comb begin
      phase = (32'(item_ff.angle) & ANGLE_MASK) << ANGLE_SHIFT;
      st_in[0] = '0;
      st_in[0].z[LANE_SIN] = fold_phase(phase);
      st_in[0].z[LANE_COS] = fold_phase(phase + QUARTER_TURN);
      st_in[0].geo.position = item_ff.position_packed;
      st_in[0].geo.dx_left = -33'(item_ff.pivot_x);
      st_in[0].geo.dx_right = 33'(item_ff.width) - 33'(item_ff.pivot_x);
      st_in[0].geo.dy_top = 33'(item_ff.height) - 33'(item_ff.pivot_y);
      st_in[0].geo.dy_bot = -33'(item_ff.pivot_y);
      st_in[0].geo.u0 = item_ff.tex_origin_u;
      st_in[0].geo.v0 = item_ff.tex_origin_v;
      st_in[0].geo.u1 = sat32(40'(item_ff.tex_origin_u) + 40'(item_ff.tex_extent_u));
      st_in[0].geo.v1 = sat32(40'(item_ff.tex_origin_v) + 40'(item_ff.tex_extent_v));
      st_in[0].geo.texture = item_ff.texture_id;
      st_in[0].geo.final_sprite = item_ff.final_sprite;
   end

   for (genvar j = 1; j < TRIG_STAGES; j++) begin : g_stage
      if (j == 1) begin : g_square
         always_comb begin
            st_in[j] = st_ff[j-1];
            for (int l = 0; l < 2; l++) begin
               st_in[j].z2[l] = 32'(mul_floor30(st_ff[j-1].z[l], st_ff[j-1].z[l]));
               st_in[j].p[l] = SINE_COEF[0];
            end
         end
      end else if (j < TRIG_STAGES - 1) begin : g_horner
         always_comb begin
            st_in[j] = st_ff[j-1];
            for (int l = 0; l < 2; l++) begin
               st_in[j].p[l] = horner_step(SINE_COEF[j-1], st_ff[j-1].p[l],
                                           st_ff[j-1].z2[l]);
            end
         end
      end else begin : g_finish
         always_comb begin
            st_in[j] = st_ff[j-1];
            for (int l = 0; l < 2; l++) begin
               st_in[j].p[l] = sine_finish(st_ff[j-1].p[l], st_ff[j-1].z[l]);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         item_v_ff <= 1'b0;
         st_v_ff <= '0;
      end else begin
         if (item_free) begin
            item_v_ff <= in_valid;
         end
         if (stage_free[0]) begin
            st_v_ff[0] <= item_v_ff;
         end
         for (int j = 1; j < TRIG_STAGES; j++) begin
            if (stage_free[j]) begin
               st_v_ff[j] <= st_v_ff[j-1];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (item_free) begin
         item_ff <= in_data;
      end
      for (int j = 0; j < TRIG_STAGES; j++) begin
         if (stage_free[j]) begin
            st_ff[j] <= st_in[j];
         end
      end
   end

   assign out_valid = st_v_ff[TRIG_STAGES-1];
   assign out_data.sin_q30 = st_ff[TRIG_STAGES-1].p[LANE_SIN];
   assign out_data.cos_q30 = st_ff[TRIG_STAGES-1].p[LANE_COS];
   assign out_data.geo = st_ff[TRIG_STAGES-1].geo;

endmodule

// ----- rtl/core/sqve_vertex_emit.sv -----
`timescale 1ns / 1ps
// sqve_vertex_emit: holds one rotated sprite and issues its six vertices,
// one multiply stage and one round/saturate stage per vertex. Uses sqve_pkg.
module sqve_vertex_emit (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   output logic                 in_ready,
   input  sqve_pkg::sprite_type in_data,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output sqve_pkg::rsp_type    rsp_data
);
   import sqve_pkg::*;

   typedef struct packed {
      logic [47:0]        position;
      logic signed [31:0] tex_u;
      logic signed [31:0] tex_v;
      logic [31:0]        texture;
      corner_type         corner;
      logic               last_of_sprite;
      logic               last_of_batch;
   } vmeta_type;

   typedef struct packed {
      logic signed [64:0] cdx;
      logic signed [64:0] sdy;
      logic signed [64:0] sdx;
      logic signed [64:0] cdy;
      vmeta_type          meta;
   } prod_type;

   sprite_type         hold_ff;
   logic               hold_v_ff;
   logic [2:0]         cnt_ff;
   logic [2:0]         cnt_in;
   prod_type           prod_ff;
   prod_type           prod_in;
   logic               prod_v_ff;
   rsp_type            rsp_ff;
   rsp_type            rsp_in;
   logic               rsp_v_ff;

   logic               out_free;
   logic               prod_free;
   logic               issue;
   logic               last_issue;
   logic               hold_free;
   corner_type         corner;
   logic               right;
   logic               top;
   logic signed [32:0] dx;
   logic signed [32:0] dy;
   logic signed [65:0] sum_x;
   logic signed [65:0] sum_y;
   logic signed [65:0] sh_x;
   logic signed [65:0] sh_y;

   assign out_free = !rsp_v_ff || rsp_ready;
   assign prod_free = !prod_v_ff || out_free;
   assign issue = hold_v_ff && prod_free;
   assign last_issue = issue && (cnt_ff == LAST_VERTEX);
   // next sprite loads in the cycle its predecessor issues the sixth vertex
   assign hold_free = !hold_v_ff || last_issue;
   assign in_ready = hold_free;

   always_comb begin
      cnt_in = cnt_ff;
      if (issue) begin
         cnt_in = last_issue ? 3'd0 : cnt_ff + 3'd1;
      end
   end

   // multiply stage
   always_comb begin
      corner = CORNER_SEQ[cnt_ff];
      right = (corner == CORNER_TR) || (corner == CORNER_BR);
      top = (corner == CORNER_TL) || (corner == CORNER_TR);
      dx = right ? hold_ff.geo.dx_right : hold_ff.geo.dx_left;
      dy = top ? hold_ff.geo.dy_top : hold_ff.geo.dy_bot;
      prod_in.cdx = 65'(hold_ff.cos_q30) * 65'(dx);
      prod_in.sdy = 65'(hold_ff.sin_q30) * 65'(dy);
      prod_in.sdx = 65'(hold_ff.sin_q30) * 65'(dx);
      prod_in.cdy = 65'(hold_ff.cos_q30) * 65'(dy);
      prod_in.meta.position = hold_ff.geo.position;
      prod_in.meta.tex_u = right ? hold_ff.geo.u1 : hold_ff.geo.u0;
      prod_in.meta.tex_v = top ? hold_ff.geo.v1 : hold_ff.geo.v0;
      prod_in.meta.texture = hold_ff.geo.texture;
      prod_in.meta.corner = corner;
      prod_in.meta.last_of_sprite = (cnt_ff == LAST_VERTEX);
      prod_in.meta.last_of_batch = (cnt_ff == LAST_VERTEX) && hold_ff.geo.final_sprite;
   end

   // round to nearest (floor of x + 1/2), then saturate
   always_comb begin
      sum_x = 66'(prod_ff.cdx) + 66'(prod_ff.sdy) + ROUND_HALF;
      sum_y = 66'(prod_ff.cdy) - 66'(prod_ff.sdx) + ROUND_HALF;
      sh_x = sum_x >>> 30;
      sh_y = sum_y >>> 30;
      rsp_in.vertex_position = prod_ff.meta.position;
      rsp_in.corner_offset_x = sat32(40'(sh_x));
      rsp_in.corner_offset_y = sat32(40'(sh_y));
      rsp_in.tex_u = prod_ff.meta.tex_u;
      rsp_in.tex_v = prod_ff.meta.tex_v;
      rsp_in.vertex_texture = prod_ff.meta.texture;
      rsp_in.corner = prod_ff.meta.corner;
      rsp_in.last_of_sprite = prod_ff.meta.last_of_sprite;
      rsp_in.last_of_batch = prod_ff.meta.last_of_batch;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_v_ff <= 1'b0;
         prod_v_ff <= 1'b0;
         rsp_v_ff <= 1'b0;
         cnt_ff <= 3'd0;
      end else begin
         cnt_ff <= cnt_in;
         if (hold_free) begin
            hold_v_ff <= in_valid;
         end
         if (prod_free) begin
            prod_v_ff <= issue;
         end
         if (out_free) begin
            rsp_v_ff <= prod_v_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (hold_free) begin
         hold_ff <= in_data;
      end
      if (prod_free) begin
         prod_ff <= prod_in;
      end
      if (out_free) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_v_ff;
   assign rsp_data = rsp_ff;

   a_batch_end_on_sprite_end: assert property (@(posedge clock) disable iff (reset)
      rsp_v_ff && rsp_ff.last_of_batch |-> rsp_ff.last_of_sprite)
      else $error("last_of_batch without last_of_sprite");

   a_sprite_ends_bottom_right: assert property (@(posedge clock) disable iff (reset)
      rsp_v_ff && rsp_ff.last_of_sprite |-> rsp_ff.corner == CORNER_BR)
      else $error("sixth vertex is not the bottom right corner");

   a_count_steps: assert property (@(posedge clock) disable iff (reset)
      issue && cnt_ff != LAST_VERTEX |=> cnt_ff == $past(cnt_ff) + 3'd1)
      else $error("vertex counter skipped");

   a_load_only_after_last: assert property (@(posedge clock) disable iff (reset)
      hold_v_ff && in_ready |-> cnt_ff == LAST_VERTEX)
      else $error("new sprite taken before six vertices issued");

endmodule

// ----- rtl/core/sprite_quad_vertex_expander_core.sv -----
`timescale 1ns / 1ps
// sprite_quad_vertex_expander_core: top level; trig pipeline feeding the vertex
// emitter. Uses sqve_pkg, sqve_trig_pipe and sqve_vertex_emit.
//
//   channel  | ports                          | moves
//   ---------+--------------------------------+------------------------------
//   request  | req_valid req_ready req_data   | one sprite per item
//   response | rsp_valid rsp_ready rsp_data   | one vertex per item, six per sprite
//
// Sustained rate is set by the single vertex output port. A sprite's first vertex
// reaches rsp_valid via input, trig stage, hold, multiply and round registers.
// Reset clears only valid bits and the vertex counter; no clearing pass.
// With rsp_ready low, up to nine sprites queue in the pipeline before
// req_ready drops; nothing is dropped or repeated.
module sprite_quad_vertex_expander_core (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  sqve_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output sqve_pkg::rsp_type rsp_data
);
   import sqve_pkg::*;

   logic       spr_valid;
   logic       spr_ready;
   sprite_type spr_data;

   sqve_trig_pipe u_trig (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_ready  (req_ready),
      .in_data   (req_data),
      .out_valid (spr_valid),
      .out_ready (spr_ready),
      .out_data  (spr_data)
   );

   sqve_vertex_emit u_emit (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (spr_valid),
      .in_ready  (spr_ready),
      .in_data   (spr_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule
